### hdl/glyph_bitmap_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Glyph rasterizer assertion macros
// Concurrent assertion forms used by the rasterizer controller.
// ----------------------------------------------------------------------------
`ifndef GLYPH_BITMAP_RASTERIZER_ASSERT_SVH
`define GLYPH_BITMAP_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GBR_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GBR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gbr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph rasterizer package
// Types, constants and command/status bundles shared by the rasterizer.
// ----------------------------------------------------------------------------
package gbr_pkg;

  localparam int CFG_W        = 11;  // configuration data width
  localparam int CFG_IDX_W    = 2;
  localparam int GLYPH_W      = 32;
  localparam int COORD_W      = 16;
  localparam int COLOR_W      = 16;
  localparam int ADDR_W       = 20;
  localparam int ADV_W        = 4;
  localparam int ROW_W        = 18;  // origin row plus offset and row count, no wrap
  localparam int COL_W        = 17;
  localparam int BITMAP_CELLS = 27;
  localparam int BITMAP_TOP   = 26;
  localparam int POS_W        = 6;   // enough for eight rows of seven cells
  localparam int YOFF_MSB     = 31;
  localparam int YOFF_LSB     = 30;
  localparam int GW_MSB       = 29;
  localparam int GW_LSB       = 27;
  localparam int ADV_EMPTY    = 4;
  localparam int RESET_DIM    = 1024;

  localparam int MAX_STRIDE_DEF = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int GLYPH_ROWS_DEF = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_ROW_STRIDE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROW,
    ST_CELL,
    ST_MARK
  } state_e;

  typedef struct packed {
    logic load;
    logic skip_row;
    logic begin_row;
    logic take_cell;
    logic end_row;
    logic mark;
  } cmd_t;

  typedef struct packed {
    logic glyph_zero;
    logic width_zero;
    logic rows_done;
    logic row_below;
    logic row_neg;
    logic bitmap_done;
    logic cell_last;
  } status_t;

endpackage

### hdl/glyph_bitmap_rasterizer.sv
// ----------------------------------------------------------------------------
// Glyph bitmap rasterizer
// Turns one packed 1-bit glyph into clipped frame-buffer pixel writes.
// ----------------------------------------------------------------------------
// Usage: raise start with glyph_word_i, origin_x_i, origin_y_i and ink_color_i;
// the request is taken at a clock edge where start is high and busy is low.
// busy stays high until the glyph's end marker has been issued.
// Results appear one per cycle at most, each on the result ports for a single
// cycle marked by result_strobe_o. Pixel writes come first (write_valid_o
// high), then one end marker with last_result_o high and the advance.
// The receiver cannot stall: every strobed result must be taken.
// Sequence: the glyph is classified, then for each glyph row the row address
// is set up (one multiply) and each bitmap cell of a visible row is taken;
// last the marker is issued. The bitmap ends after 27 cells. Each result is
// registered and appears in the cycle after its cell.
// Configuration writes (index 0 image width, 1 height, 2 stride) are always
// ready and are to be made by the user while the block is idle; the block
// itself does not enforce this. Unknown indexes are ignored.
// Reset returns all dimensions to 1024 and the controller to idle.
// ----------------------------------------------------------------------------
module glyph_bitmap_rasterizer
  import gbr_pkg::*;
#(
  parameter int MAX_STRIDE = MAX_STRIDE_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [GLYPH_W-1:0]        glyph_word_i,
  input  logic signed [COORD_W-1:0] origin_x_i,
  input  logic signed [COORD_W-1:0] origin_y_i,
  input  logic [COLOR_W-1:0]        ink_color_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output logic                      result_strobe_o,
  output logic                      write_valid_o,
  output logic [ADDR_W-1:0]         pixel_address_o,
  output logic [COLOR_W-1:0]        pixel_color_o,
  output logic [ADV_W-1:0]          advance_o,
  output logic                      last_result_o
);

  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int SW = $clog2(MAX_STRIDE+1);
  localparam int HEIGHT_RST = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;
  localparam int STRIDE_RST = (RESET_DIM > MAX_STRIDE) ? MAX_STRIDE : RESET_DIM;

  logic [CFG_W-1:0] width_q;
  logic [HW-1:0]    height_q;
  logic [SW-1:0]    stride_q;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  // Height and stride saturate at their maximums on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(RESET_DIM);
      height_q <= HW'(HEIGHT_RST);
      stride_q <= SW'(STRIDE_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i;
        end
        CFG_IMAGE_HEIGHT: begin
          height_q <= (int'(cfg_data_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
        end
        CFG_ROW_STRIDE: begin
          stride_q <= (int'(cfg_data_i) > MAX_STRIDE) ? SW'(MAX_STRIDE) : SW'(cfg_data_i);
        end
        default: begin
          width_q <= width_q;
        end
      endcase
    end
  end

  gbr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  gbr_datapath #(
    .MAX_STRIDE (MAX_STRIDE),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GLYPH_ROWS (GLYPH_ROWS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .glyph_word_i    (glyph_word_i),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .ink_color_i     (ink_color_i),
    .image_width_i   (width_q),
    .image_height_i  (height_q),
    .row_stride_i    (stride_q),
    .result_strobe_o (result_strobe_o),
    .write_valid_o   (write_valid_o),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .advance_o       (advance_o),
    .last_result_o   (last_result_o)
  );

endmodule

### hdl/gbr_ctrl.sv
// ----------------------------------------------------------------------------
// Glyph rasterizer controller
// Sequences one glyph row by row and cell by cell, then the end marker.
// ----------------------------------------------------------------------------
`include "glyph_bitmap_rasterizer_assert.svh"

module gbr_ctrl
  import gbr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.glyph_zero || status_i.width_zero) state_d = ST_MARK;
        else state_d = ST_ROW;
      end
      ST_ROW: begin
        if (status_i.rows_done || status_i.row_below) state_d = ST_MARK;
        else if (!status_i.row_neg) state_d = ST_CELL;
      end
      ST_CELL: begin
        if (status_i.bitmap_done) state_d = ST_MARK;
        else if (status_i.cell_last) state_d = ST_ROW;
      end
      ST_MARK: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_ROW: begin
        if (!status_i.rows_done && !status_i.row_below) begin
          cmd_o.skip_row  = status_i.row_neg;
          cmd_o.begin_row = !status_i.row_neg;
        end
      end
      ST_CELL: begin
        if (!status_i.bitmap_done) begin
          cmd_o.take_cell = 1'b1;
          cmd_o.end_row   = status_i.cell_last;
        end
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  `GBR_ASSERT_NEXT(a_mark_then_idle, clk_i, rst_ni, state_q == ST_MARK, state_q == ST_IDLE, "marker not followed by idle")
  `GBR_ASSERT_NEXT(a_accept_to_check, clk_i, rst_ni, start && !busy, state_q == ST_CHECK, "accepted request did not start")
  `GBR_ASSERT_IMPLY(a_cell_in_bitmap, clk_i, rst_ni, cmd_o.take_cell, !status_i.bitmap_done && !status_i.width_zero, "cell consumed past bitmap")

endmodule

### hdl/gbr_datapath.sv
// ----------------------------------------------------------------------------
// Glyph rasterizer datapath
// Holds the glyph, walks its bitmap, clips cells and forms result words.
// ----------------------------------------------------------------------------
module gbr_datapath
  import gbr_pkg::*;
#(
  parameter int MAX_STRIDE = MAX_STRIDE_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cmd_t                                  cmd_i,
  output status_t                               status_o,
  input  logic [GLYPH_W-1:0]                    glyph_word_i,
  input  logic signed [COORD_W-1:0]             origin_x_i,
  input  logic signed [COORD_W-1:0]             origin_y_i,
  input  logic [COLOR_W-1:0]                    ink_color_i,
  input  logic [CFG_W-1:0]                      image_width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]       image_height_i,
  input  logic [$clog2(MAX_STRIDE+1)-1:0]       row_stride_i,
  output logic                                  result_strobe_o,
  output logic                                  write_valid_o,
  output logic [ADDR_W-1:0]                     pixel_address_o,
  output logic [COLOR_W-1:0]                    pixel_color_o,
  output logic [ADV_W-1:0]                      advance_o,
  output logic                                  last_result_o
);

  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int SW = $clog2(MAX_STRIDE+1);
  localparam int PW = HW + SW;
  localparam int RW = $clog2(GLYPH_ROWS+1);

  logic [GLYPH_W-1:0]       glyph_q;
  logic [BITMAP_CELLS-1:0]  bm_q;
  logic signed [COORD_W-1:0] ox_q;
  logic [COLOR_W-1:0]       ink_q;
  logic signed [ROW_W-1:0]  row_q;
  logic [RW-1:0]            rcnt_q;
  logic [POS_W-1:0]         pos_q;
  logic [2:0]               col_idx_q;
  logic [ADDR_W-1:0]        row_base_q;

  logic [2:0]               gw;
  logic signed [ROW_W-1:0]  height_s;
  logic signed [COL_W-1:0]  col;
  logic                     col_ok;
  logic                     emit;
  logic [PW-1:0]            prod;

  assign gw       = glyph_q[GW_MSB:GW_LSB];
  assign height_s = $signed(ROW_W'(image_height_i));
  assign col      = COL_W'(ox_q) + $signed(COL_W'(col_idx_q));
  assign col_ok   = !col[COL_W-1] && (col[COORD_W-1:0] < COORD_W'(image_width_i));
  assign emit     = cmd_i.take_cell && bm_q[BITMAP_TOP] && col_ok;
  // The row is known to lie in [0, image_height) here, so its low bits hold it.
  assign prod     = PW'(row_q[HW-1:0]) * PW'(row_stride_i);

  assign status_o.glyph_zero  = (glyph_q == '0);
  assign status_o.width_zero  = (gw == 3'd0);
  assign status_o.rows_done   = (rcnt_q == RW'(GLYPH_ROWS));
  assign status_o.row_below   = (row_q >= height_s);
  assign status_o.row_neg     = row_q[ROW_W-1];
  assign status_o.bitmap_done = (pos_q >= POS_W'(BITMAP_CELLS));
  assign status_o.cell_last   = (col_idx_q == gw - 3'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      glyph_q   <= glyph_word_i;
      bm_q      <= glyph_word_i[BITMAP_CELLS-1:0];
      ox_q      <= origin_x_i;
      ink_q     <= ink_color_i;
      row_q     <= ROW_W'(origin_y_i) + $signed(ROW_W'(glyph_word_i[YOFF_MSB:YOFF_LSB]));
      rcnt_q    <= '0;
      pos_q     <= '0;
      col_idx_q <= '0;
    end else begin
      if (cmd_i.skip_row) begin
        bm_q  <= bm_q << gw;
        pos_q <= pos_q + POS_W'(gw);
      end
      if (cmd_i.begin_row) begin
        row_base_q <= ADDR_W'(prod);
        col_idx_q  <= '0;
      end
      if (cmd_i.take_cell) begin
        bm_q      <= bm_q << 1;
        pos_q     <= pos_q + POS_W'(1);
        col_idx_q <= col_idx_q + 3'd1;
      end
      if (cmd_i.skip_row || cmd_i.end_row) begin
        row_q  <= row_q + ROW_W'(1);
        rcnt_q <= rcnt_q + RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_strobe_o <= 1'b0;
    end else begin
      result_strobe_o <= emit || cmd_i.mark;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      write_valid_o   <= 1'b1;
      pixel_address_o <= row_base_q + ADDR_W'(col[COORD_W-1:0]);
      pixel_color_o   <= ink_q;
      advance_o       <= '0;
      last_result_o   <= 1'b0;
    end else if (cmd_i.mark) begin
      write_valid_o   <= 1'b0;
      pixel_address_o <= '0;
      pixel_color_o   <= '0;
      if (status_o.glyph_zero) advance_o <= ADV_W'(ADV_EMPTY);
      else if (status_o.width_zero) advance_o <= '0;
      else advance_o <= ADV_W'(gw) + ADV_W'(1);
      last_result_o   <= 1'b1;
    end
  end

endmodule
